// ===== rtl/rgbh_pkg.sv =====
// Shared constants, types and helpers for the RGB colour histogram block.
// Used by the controller, the datapath and the top level; depends on nothing.
package rgbh_pkg;

  localparam int MAX_BINS_LOG2 = 3;
  localparam int COUNT_BITS    = 24;
  localparam int FRACTION_BITS = 16;
  localparam int CHAN_BITS     = 8;
  localparam int OP_W          = 2;
  localparam int CFG_W         = 2;

  localparam int ADDR_W      = 3 * MAX_BINS_LOG2;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int FRAC_W      = FRACTION_BITS + 1;
  localparam int LOG2_W      = $clog2(MAX_BINS_LOG2 + 1);
  localparam int SHIFT_W     = $clog2(CHAN_BITS + 1);
  localparam int DIV_CNT_W   = $clog2(FRACTION_BITS);

  localparam logic [CFG_W-1:0]      BINS_LOG2_RESET = CFG_W'(3);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX       = '1;
  localparam logic [FRAC_W-1:0]     FRAC_ONE        = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [DIV_CNT_W-1:0]  DIV_LAST        = DIV_CNT_W'(FRACTION_BITS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } rgbh_op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_UPDATE,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_RESULT
  } rgbh_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic clr_start;
    logic clr_step;
    logic wr_inc;
    logic div_start;
    logic div_step;
    logic out_load;
  } rgbh_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic div_last;
  } rgbh_status_t;

  // Saturating increment of a counter
  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ===== rtl/rgbh_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package dependency.
module rgbh_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rgbh_ctrl.sv =====
// Sequencing state machine for the colour histogram: clear sweep, pixel
// update, bin read with division, and the result register handshake. Uses rgbh_pkg.
module rgbh_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [rgbh_pkg::OP_W-1:0] in_operation,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  rgbh_pkg::rgbh_status_t st,
  output rgbh_pkg::rgbh_cmd_t   cmd
);
  import rgbh_pkg::*;

  rgbh_state_t state_r, state_nxt;
  rgbh_op_t    op_r, op_nxt;
  rgbh_op_t    in_op;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign in_op     = rgbh_op_t'(in_operation);
  assign slot_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      ST_CLEAR: begin
        if (st.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt = in_op;
          case (in_op)
            OP_ADD, OP_READ: state_nxt = ST_FETCH;
            OP_CLEAR:        state_nxt = ST_CLEAR;
            default:         state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: begin
        state_nxt = (op_r == OP_ADD) ? ST_UPDATE : ST_DIV_LOAD;
      end
      ST_UPDATE:   state_nxt = ST_IDLE;
      ST_DIV_LOAD: state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (st.div_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load      = in_valid;
        cmd.clr_start = in_valid && (in_op == OP_CLEAR);
      end
      ST_UPDATE:   cmd.wr_inc    = 1'b1;
      ST_DIV_LOAD: cmd.div_start = 1'b1;
      ST_DIVIDE:   cmd.div_step  = 1'b1;
      ST_RESULT:   cmd.out_load  = slot_free;
      default: ;
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      op_r        <= OP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Checks
  a_idle_no_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(cmd.wr_inc || cmd.clr_step || cmd.div_step))
    else $error("store or divider active while idle");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR && st.clr_last) |=> (state_r == ST_IDLE))
    else $error("clear sweep did not return to idle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a waiting item");

endmodule

// ===== rtl/rgbh_dp.sv =====
// Datapath for the colour histogram: bin index, bin store RAM, pixel total,
// bit-serial fraction divider and result registers. Uses rgbh_pkg and rgbh_ram.
module rgbh_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  rgbh_pkg::rgbh_cmd_t               cmd,
  output rgbh_pkg::rgbh_status_t            st,
  input  logic                              cfg_we,
  input  logic [rgbh_pkg::CFG_W-1:0]        cfg_bins_log2,
  input  logic [rgbh_pkg::OP_W-1:0]         in_operation,
  input  logic [rgbh_pkg::CHAN_BITS-1:0]    in_red,
  input  logic [rgbh_pkg::CHAN_BITS-1:0]    in_green,
  input  logic [rgbh_pkg::CHAN_BITS-1:0]    in_blue,
  input  logic [rgbh_pkg::ADDR_W-1:0]       in_read_index,
  output logic [rgbh_pkg::ADDR_W-1:0]       out_bin_number,
  output logic [rgbh_pkg::COUNT_BITS-1:0]   out_bin_count,
  output logic [rgbh_pkg::FRAC_W-1:0]       out_fraction,
  output logic [rgbh_pkg::COUNT_BITS-1:0]   out_total_pixels,
  output logic                              out_no_pixels
);
  import rgbh_pkg::*;

  logic [CFG_W-1:0]      bins_log2_r;
  logic [LOG2_W-1:0]     eff_log2;
  logic [SHIFT_W-1:0]    shift_amt;
  logic [ADDR_W-1:0]     r_q, g_q, b_q, pix_idx;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [ADDR_W-1:0]     clr_cnt_r;
  logic [COUNT_BITS-1:0] total_r;
  logic [COUNT_BITS-1:0] ram_rdata, ram_wdata;
  logic [ADDR_W-1:0]     ram_waddr;
  logic                  ram_we;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS:0]   rem_r, rem_sh, div_sub;
  logic                  take;
  logic [FRACTION_BITS-1:0] quo_r;
  logic [DIV_CNT_W-1:0]  div_cnt_r;
  logic [ADDR_W-1:0]     out_bin_number_r;
  logic [COUNT_BITS-1:0] out_bin_count_r, out_total_r;
  logic [FRAC_W-1:0]     out_fraction_r, frac_nxt;
  logic                  out_no_pixels_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_log2_r <= BINS_LOG2_RESET;
    end else if (cfg_we) begin
      bins_log2_r <= cfg_bins_log2;
    end
  end

  // Quantise the pixel and form the bin index, red fastest
  assign eff_log2  = (bins_log2_r > MAX_BINS_LOG2) ? LOG2_W'(MAX_BINS_LOG2)
                                                   : LOG2_W'(bins_log2_r);
  assign shift_amt = SHIFT_W'(CHAN_BITS) - SHIFT_W'(eff_log2);
  assign r_q       = ADDR_W'(in_red >> shift_amt);
  assign g_q       = ADDR_W'(in_green >> shift_amt);
  assign b_q       = ADDR_W'(in_blue >> shift_amt);
  assign pix_idx   = (b_q << {eff_log2, 1'b0}) | (g_q << eff_log2) | r_q;
  assign idx_nxt   = (rgbh_op_t'(in_operation) == OP_READ) ? in_read_index : pix_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= idx_nxt;
    end
  end

  // Clear sweep counter and pixel total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      total_r   <= '0;
    end else begin
      if (cmd.clr_start) begin
        clr_cnt_r <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.clr_start) begin
        total_r <= '0;
      end else if (cmd.wr_inc) begin
        total_r <= sat_inc(total_r);
      end
    end
  end

  assign st.clr_last = &clr_cnt_r;

  // Bin store: zero during the sweep, saturating increment on a pixel
  assign ram_we    = cmd.wr_inc || cmd.clr_step;
  assign ram_waddr = cmd.clr_step ? clr_cnt_r : idx_r;
  assign ram_wdata = cmd.clr_step ? '0 : sat_inc(ram_rdata);

  rgbh_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  // Restoring divider: one fraction bit per cycle
  assign rem_sh  = {rem_r[COUNT_BITS-1:0], 1'b0};
  assign take    = rem_sh >= {1'b0, total_r};
  assign div_sub = rem_sh - {1'b0, total_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      cnt_r <= ram_rdata;
      rem_r <= {1'b0, ram_rdata};
      quo_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= take ? div_sub : rem_sh;
      quo_r <= {quo_r[FRACTION_BITS-2:0], take};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  assign st.div_last = (div_cnt_r == DIV_LAST);

  // Fraction: zero when empty, full when the bin holds every pixel
  always_comb begin
    if (total_r == '0) begin
      frac_nxt = '0;
    end else if (cnt_r >= total_r) begin
      frac_nxt = FRAC_ONE;
    end else begin
      frac_nxt = {1'b0, quo_r};
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_bin_number_r <= idx_r;
      out_bin_count_r  <= cnt_r;
      out_fraction_r   <= frac_nxt;
      out_total_r      <= total_r;
      out_no_pixels_r  <= (total_r == '0);
    end
  end

  assign out_bin_number   = out_bin_number_r;
  assign out_bin_count    = out_bin_count_r;
  assign out_fraction     = out_fraction_r;
  assign out_total_pixels = out_total_r;
  assign out_no_pixels    = out_no_pixels_r;

  // Checks
  a_bin_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (cnt_r <= total_r))
    else $error("bin count above pixel total");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_inc && total_r != COUNT_MAX) |=> (total_r == $past(total_r) + 1'b1))
    else $error("pixel total did not advance by one");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (out_fraction_r <= FRAC_ONE))
    else $error("fraction above one");

endmodule

// ===== rtl/rgb_color_histogram_core.sv =====
// Joint 3-D RGB colour histogram with normalised bin readout.
// Channels: in_* (valid/ready) carries one item: add a pixel, read a bin or
//   clear. out_* (valid/ready) returns one item per read. cfg_* (valid/ready,
//   always ready) writes bins_log2; write it only while the block is idle.
// Controller sequence per item:
//   add pixel: accept, store read, store write-back.
//   read bin:  accept, store read, divider load, divide, result register; the
//              fraction comes from a divider that yields one bit per cycle.
//   clear:     accept, then a sweep over all STORE_DEPTH entries, one store entry zeroed per cycle.
// Reset: the block sweeps the whole store to zero with in_ready
//   low; configuration writes are taken during the sweep.
// Stall: a finished read waits in the output register; the next item is
//   accepted meanwhile, and a following read holds in its last step until
//   the waiting item is taken.
// Depends on rgbh_pkg, rgbh_ctrl, rgbh_dp and rgbh_ram.
module rgb_color_histogram_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbh_pkg::CFG_W-1:0]        cfg_bins_log2,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rgbh_pkg::OP_W-1:0]         in_operation,
  input  logic [rgbh_pkg::CHAN_BITS-1:0]    in_red,
  input  logic [rgbh_pkg::CHAN_BITS-1:0]    in_green,
  input  logic [rgbh_pkg::CHAN_BITS-1:0]    in_blue,
  input  logic [rgbh_pkg::ADDR_W-1:0]       in_read_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [rgbh_pkg::ADDR_W-1:0]       out_bin_number,
  output logic [rgbh_pkg::COUNT_BITS-1:0]   out_bin_count,
  output logic [rgbh_pkg::FRAC_W-1:0]       out_fraction,
  output logic [rgbh_pkg::COUNT_BITS-1:0]   out_total_pixels,
  output logic                              out_no_pixels
);
  import rgbh_pkg::*;

  rgbh_cmd_t    cmd;
  rgbh_status_t st;

  assign cfg_ready = 1'b1;

  rgbh_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_operation(in_operation),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .st          (st),
    .cmd         (cmd)
  );

  rgbh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_bins_log2   (cfg_bins_log2),
    .in_operation    (in_operation),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_read_index   (in_read_index),
    .out_bin_number  (out_bin_number),
    .out_bin_count   (out_bin_count),
    .out_fraction    (out_fraction),
    .out_total_pixels(out_total_pixels),
    .out_no_pixels   (out_no_pixels)
  );

endmodule

// ===== test/rgb_color_histogram_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for rgb_color_histogram_core: sends pixel, read, clear and no-op items,
// mirrors the bin store locally and checks every bin readout item field by field.
// Depends on rgbh_pkg and the rgb_color_histogram_core RTL.
module rgb_color_histogram_core_tb;
  import rgbh_pkg::*;

  // Longest item (clear) plus margin, used before register writes and at the end
  localparam int SETTLE_CYCLES = 600;
  localparam int PRINT_LIMIT   = 40;

  typedef struct {
    rgbh_op_t               op;
    logic [CHAN_BITS-1:0]   red;
    logic [CHAN_BITS-1:0]   green;
    logic [CHAN_BITS-1:0]   blue;
    logic [ADDR_W-1:0]      read_index;
  } hist_item_t;

  typedef struct {
    logic [ADDR_W-1:0]      bin_number;
    logic [COUNT_BITS-1:0]  bin_count;
    logic [FRAC_W-1:0]      fraction;
    logic [COUNT_BITS-1:0]  total_pixels;
    logic                   no_pixels;
  } bin_report_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_bins_log2;
  logic                   in_valid;
  logic                   in_ready;
  logic [OP_W-1:0]        in_operation;
  logic [CHAN_BITS-1:0]   in_red;
  logic [CHAN_BITS-1:0]   in_green;
  logic [CHAN_BITS-1:0]   in_blue;
  logic [ADDR_W-1:0]      in_read_index;
  logic                   out_valid;
  logic                   out_ready;
  logic [ADDR_W-1:0]      out_bin_number;
  logic [COUNT_BITS-1:0]  out_bin_count;
  logic [FRAC_W-1:0]      out_fraction;
  logic [COUNT_BITS-1:0]  out_total_pixels;
  logic                   out_no_pixels;

  // Local copy of the histogram state
  logic [COUNT_BITS-1:0]  mirror_bins [STORE_DEPTH];
  logic [COUNT_BITS-1:0]  mirror_total;
  logic [CFG_W-1:0]       mirror_log2;
  logic [ADDR_W-1:0]      touched_bins [$];
  bin_report_t            pending_bin_reads [$];

  logic [CHAN_BITS-1:0]   palette [4][3];
  int                     mismatch_count;
  int                     tx_burst_left;
  bit                     tx_gaps_on;
  bit                     rx_steady;
  int                     rx_hold_req;

  rgb_color_histogram_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bins_log2    (cfg_bins_log2),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bin_number   (out_bin_number),
    .out_bin_count    (out_bin_count),
    .out_fraction     (out_fraction),
    .out_total_pixels (out_total_pixels),
    .out_no_pixels    (out_no_pixels)
  );

  always #2 clk = ~clk;

  // Saturating counter step
  function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  // Bin of a pixel: red fastest, blue slowest
  function automatic logic [ADDR_W-1:0] pixel_bin(input logic [CHAN_BITS-1:0] r, g, b,
                                                  input logic [CFG_W-1:0] log2);
    int unsigned w;
    int unsigned sh;
    int unsigned rq;
    int unsigned gq;
    int unsigned bq;
    w  = (log2 > MAX_BINS_LOG2) ? MAX_BINS_LOG2 : log2;
    sh = CHAN_BITS - w;
    rq = r;
    gq = g;
    bq = b;
    return ADDR_W'(((bq >> sh) << (2 * w)) | ((gq >> sh) << w) | (rq >> sh));
  endfunction

  // Advance the mirrored histogram by one accepted item
  function automatic void apply_to_histogram(input hist_item_t it);
    logic [ADDR_W-1:0] idx;
    bin_report_t       rep;
    longint unsigned   frac;
    case (it.op)
      OP_ADD: begin
        idx = pixel_bin(it.red, it.green, it.blue, mirror_log2);
        mirror_bins[idx] = count_up(mirror_bins[idx]);
        mirror_total = count_up(mirror_total);
        touched_bins.push_back(idx);
        if (touched_bins.size() > 64) void'(touched_bins.pop_front());
      end
      OP_CLEAR: begin
        foreach (mirror_bins[i]) mirror_bins[i] = '0;
        mirror_total = '0;
        touched_bins.delete();
      end
      OP_READ: begin
        rep.bin_number   = it.read_index;
        rep.bin_count    = mirror_bins[it.read_index];
        rep.total_pixels = mirror_total;
        rep.no_pixels    = (mirror_total == '0);
        frac = 0;
        if (mirror_total != '0) begin
          frac = (64'(rep.bin_count) << FRACTION_BITS) / 64'(mirror_total);
          if (frac > FRAC_ONE) frac = FRAC_ONE;
        end
        rep.fraction = FRAC_W'(frac);
        pending_bin_reads.push_back(rep);
      end
      default: ;
    endcase
  endfunction

  // Channel near a palette colour, with some extremes and full-range values
  function automatic logic [CHAN_BITS-1:0] channel_value(input logic [CHAN_BITS-1:0] base);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return base ^ CHAN_BITS'($urandom_range(0, 7));
    if (sel == 5) return '0;
    if (sel == 6) return '1;
    return CHAN_BITS'($urandom);
  endfunction

  // Bin to read: mostly recently filled ones, also edges of the live range
  function automatic logic [ADDR_W-1:0] pick_read_index();
    int sel;
    int w;
    sel = $urandom_range(0, 99);
    w   = mirror_log2;
    if (sel < 55 && touched_bins.size() > 0)
      return touched_bins[$urandom_range(0, touched_bins.size() - 1)];
    if (sel < 60) return '0;
    if (sel < 65) return '1;
    if (sel < 70) return ADDR_W'((1 << (3 * w)) - 1);
    if (sel < 75) return ADDR_W'(1 << (3 * w));
    return ADDR_W'($urandom);
  endfunction

  function automatic void new_palette();
    foreach (palette[k, c]) palette[k][c] = CHAN_BITS'($urandom);
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Offer one item at the falling edge, hold it until taken, then predict
  task automatic send_item(input hist_item_t it);
    int gap;
    @(negedge clk);
    if (tx_gaps_on && tx_burst_left == 0) begin
      gap = $urandom_range(1, 6);
      tx_burst_left = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else if (tx_burst_left > 0) begin
      tx_burst_left--;
    end
    in_valid      <= 1'b1;
    in_operation  <= it.op;
    in_red        <= it.red;
    in_green      <= it.green;
    in_blue       <= it.blue;
    in_read_index <= it.read_index;
    do @(posedge clk); while (!in_ready);
    apply_to_histogram(it);
  endtask

  task automatic send_pixel(input logic [CHAN_BITS-1:0] r, g, b);
    hist_item_t it;
    it.op = OP_ADD;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.read_index = ADDR_W'($urandom);
    send_item(it);
  endtask

  task automatic send_read(input logic [ADDR_W-1:0] idx);
    hist_item_t it;
    it.op = OP_READ;
    it.red = CHAN_BITS'($urandom);
    it.green = CHAN_BITS'($urandom);
    it.blue = CHAN_BITS'($urandom);
    it.read_index = idx;
    send_item(it);
  endtask

  // Clear or no-op item with random unused fields
  task automatic send_plain(input rgbh_op_t op);
    hist_item_t it;
    it.op = op;
    it.red = CHAN_BITS'($urandom);
    it.green = CHAN_BITS'($urandom);
    it.blue = CHAN_BITS'($urandom);
    it.read_index = ADDR_W'($urandom);
    send_item(it);
  endtask

  task automatic send_palette_pixel();
    int k;
    k = $urandom_range(0, 3);
    send_pixel(channel_value(palette[k][0]), channel_value(palette[k][1]),
               channel_value(palette[k][2]));
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 64) send_palette_pixel();
    else if (pick < 94) send_read(pick_read_index());
    else if (pick < 96) send_plain(OP_CLEAR);
    else send_plain(OP_NONE);
  endtask

  // Drop valid, wait for every readout, then let a clear run out
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bin_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_bins_log2(input logic [CFG_W-1:0] v);
    settle_block();
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_bins_log2 <= v;
    do @(posedge clk); while (!cfg_ready);
    mirror_log2 = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Empty reads, channel extremes, one full bin, no-op and clear
  task automatic test_directed();
    send_read('0);
    send_read('1);
    send_plain(OP_NONE);
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_read(pixel_bin(8'h00, 8'h00, 8'h00, mirror_log2));
    send_read(pixel_bin(8'hFF, 8'hFF, 8'hFF, mirror_log2));
    send_read(pixel_bin(8'hFF, 8'h00, 8'h00, mirror_log2));
    send_read(pixel_bin(8'h00, 8'hFF, 8'h00, mirror_log2));
    send_read(pixel_bin(8'h00, 8'h00, 8'hFF, mirror_log2));
    send_read(9'd300);
    send_plain(OP_CLEAR);
    send_read('1);
    // All pixels in one bin: fraction reaches one
    repeat (3) send_pixel(8'd128, 8'd64, 8'd32);
    send_read(pixel_bin(8'd128, 8'd64, 8'd32, mirror_log2));
    send_plain(OP_NONE);
    send_pixel(8'hAA, 8'h55, 8'hAA);
    send_read(pixel_bin(8'd128, 8'd64, 8'd32, mirror_log2));
    send_read(pixel_bin(8'hAA, 8'h55, 8'hAA, mirror_log2));
  endtask

  // Every binning width; one change keeps the counts of the coarser binning
  task automatic test_bin_settings();
    for (int i = 0; i < 4; i++) begin
      write_bins_log2(CFG_W'((i + 3) % 4));
      new_palette();
      if (i != 2) send_plain(OP_CLEAR);
      for (int n = 0; n < 60; n++) begin
        if (n % 3 == 2) send_read(pick_read_index());
        else send_palette_pixel();
      end
    end
  endtask

  // Hold the receiver off while reads keep coming, so the input stalls
  task automatic test_output_hold();
    tx_gaps_on = 1'b0;
    rx_hold_req = 300;
    for (int n = 0; n < 24; n++) begin
      if (n % 4 == 3) send_palette_pixel();
      else send_read(pick_read_index());
    end
    tx_gaps_on = 1'b1;
  endtask

  // Random segments, each under a fresh binning width and idling mix
  task automatic test_random_traffic();
    for (int seg = 0; seg < 6; seg++) begin
      tx_gaps_on = (seg % 3) != 1;
      rx_steady  = (seg % 3) == 2;
      write_bins_log2(CFG_W'($urandom_range(0, 3)));
      new_palette();
      for (int n = 0; n < 175; n++) send_random_item();
    end
    tx_gaps_on = 1'b1;
    rx_steady  = 1'b0;
  endtask

  // Receiver: its own stall pattern, plus long holds on request
  initial begin : receiver
    int hold_left;
    int phase;
    hold_left = 0;
    phase = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req > 0) begin
        hold_left = rx_hold_req;
        rx_hold_req = 0;
      end else if (hold_left == 0 && !rx_steady && $urandom_range(0, 40) == 0) begin
        hold_left = $urandom_range(5, 30);
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        phase = (phase + 1) % 11;
        out_ready <= (phase < 6) || ($urandom_range(0, 2) == 0);
      end
    end
  end

  // Compare each readout item with the oldest prediction
  always @(posedge clk) begin : check_readout
    bin_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bin_reads.size() == 0) begin
        report_mismatch("readout with none pending, bin", out_bin_number, 0);
      end else begin
        want = pending_bin_reads.pop_front();
        if (out_bin_number !== want.bin_number)
          report_mismatch("bin_number", out_bin_number, want.bin_number);
        if (out_bin_count !== want.bin_count)
          report_mismatch("bin_count", out_bin_count, want.bin_count);
        if (out_fraction !== want.fraction)
          report_mismatch("fraction", out_fraction, want.fraction);
        if (out_total_pixels !== want.total_pixels)
          report_mismatch("total_pixels", out_total_pixels, want.total_pixels);
        if (out_no_pixels !== want.no_pixels)
          report_mismatch("no_pixels", out_no_pixels, want.no_pixels);
      end
    end
  end

  // Sequence the tests
  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_bins_log2 = BINS_LOG2_RESET;
    in_valid      = 1'b0;
    in_operation  = OP_NONE;
    in_red        = '0;
    in_green      = '0;
    in_blue       = '0;
    in_read_index = '0;
    foreach (mirror_bins[i]) mirror_bins[i] = '0;
    mirror_total   = '0;
    mirror_log2    = BINS_LOG2_RESET;
    mismatch_count = 0;
    tx_burst_left  = 0;
    tx_gaps_on     = 1'b1;
    rx_steady      = 1'b0;
    rx_hold_req    = 0;
    new_palette();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_bin_settings();
    test_output_hold();
    test_random_traffic();
    settle_block();

    if (mismatch_count == 0)
      $display("rgb_color_histogram_core verification clean");
    else
      $display("rgb_color_histogram_core verification failed");
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("rgb_color_histogram_core verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rgbh_pkg.sv
rtl/rgbh_ram.sv
rtl/rgbh_ctrl.sv
rtl/rgbh_dp.sv
rtl/rgb_color_histogram_core.sv
test/rgb_color_histogram_core_tb.sv
